// ----- rtl/core/eabv_pkg.sv -----
// ----------------------------------------------------------------------------
// eabv_pkg
// shared constants, cordic arctangent table and helpers for the euler unit
// ----------------------------------------------------------------------------
`default_nettype none
package eabv_pkg;
    localparam int ANGLE_BITS = 16;
    localparam int FRAC_BITS  = 14;
    localparam int QBITS      = 30;
    localparam int ITERS      = 30;
    localparam int OUT_W      = FRAC_BITS + 2;
    localparam int CW         = 33;
    localparam int ZW         = 32;
    localparam int PW         = 2 * CW;
    localparam int SH         = QBITS - FRAC_BITS;
    localparam int IW         = $clog2(ITERS);
    localparam int LAT        = ITERS + 5;

    localparam logic signed [CW-1:0] GAIN_INV = CW'(652032874);
    localparam logic [ZW-1:0] QUARTER_MASK = 32'h3FFF_FFFF;

    localparam logic [0:0] REG_RIGHT_NEGATED = 1'b0;

    typedef logic signed [CW-1:0] t_q30;

    typedef struct packed {
        t_q30 x;
        t_q30 y;
        logic signed [ZW-1:0] z;
        logic [1:0] quad;
    } t_rot;

    function automatic logic signed [ZW-1:0] atan_at(input logic [IW-1:0] i);
        logic signed [ZW-1:0] v;
        case (i)
            5'd0: v = 32'h20000000;  5'd1: v = 32'h12E4051E;
            5'd2: v = 32'h09FB385B;  5'd3: v = 32'h051111D4;
            5'd4: v = 32'h028B0D43;  5'd5: v = 32'h0145D7E1;
            5'd6: v = 32'h00A2F61E;  5'd7: v = 32'h00517C55;
            5'd8: v = 32'h0028BE53;  5'd9: v = 32'h00145F2F;
            5'd10: v = 32'h000A2F98; 5'd11: v = 32'h000517CC;
            5'd12: v = 32'h00028BE6; 5'd13: v = 32'h000145F3;
            5'd14: v = 32'h0000A2FA; 5'd15: v = 32'h0000517D;
            5'd16: v = 32'h000028BE; 5'd17: v = 32'h0000145F;
            5'd18: v = 32'h00000A30; 5'd19: v = 32'h00000518;
            5'd20: v = 32'h0000028C; 5'd21: v = 32'h00000146;
            5'd22: v = 32'h000000A3; 5'd23: v = 32'h00000051;
            5'd24: v = 32'h00000029; 5'd25: v = 32'h00000014;
            5'd26: v = 32'h0000000A; 5'd27: v = 32'h00000005;
            5'd28: v = 32'h00000003; 5'd29: v = 32'h00000001;
            default: v = '0;
        endcase
        return v;
    endfunction

    function automatic t_q30 mulq(input t_q30 a, input t_q30 b);
        logic signed [PW-1:0] p;
        p = PW'(a) * PW'(b);
        return t_q30'(p >>> QBITS);
    endfunction

    function automatic logic [OUT_W-1:0] finish(input logic signed [CW+1:0] v);
        logic signed [CW+1:0] r;
        r = (v + (CW+2)'(1 << (SH - 1))) >>> SH;
        if (r > (CW+2)'(1 << FRAC_BITS)) r = (CW+2)'(1 << FRAC_BITS);
        if (r < -(CW+2)'(1 << FRAC_BITS)) r = -(CW+2)'(1 << FRAC_BITS);
        return r[OUT_W-1:0];
    endfunction
endpackage
`default_nettype wire

// ----- rtl/core/eabv_cordic_cell.sv -----
// ----------------------------------------------------------------------------
// eabv_cordic_cell
// one registered cordic micro-rotation for the three angles
// ----------------------------------------------------------------------------
`default_nettype none
module eabv_cordic_cell import eabv_pkg::*; (
    input  wire logic            i_clk,
    input  wire logic            i_en,
    input  wire logic [IW-1:0]   i_step,
    input  wire t_rot            i_rot [3],
    output t_rot                 o_rot [3]
);
    t_rot r_rot [3];
    t_rot n_rot [3];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_rot[k] = i_rot[k];
            if (!i_rot[k].z[ZW-1]) begin
                n_rot[k].x = i_rot[k].x - (i_rot[k].y >>> i_step);
                n_rot[k].y = i_rot[k].y + (i_rot[k].x >>> i_step);
                n_rot[k].z = i_rot[k].z - atan_at(i_step);
            end else begin
                n_rot[k].x = i_rot[k].x + (i_rot[k].y >>> i_step);
                n_rot[k].y = i_rot[k].y - (i_rot[k].x >>> i_step);
                n_rot[k].z = i_rot[k].z + atan_at(i_step);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rot <= n_rot;
        end
    end
    assign o_rot = r_rot;
endmodule
`default_nettype wire

// ----- rtl/core/euler_angles_to_basis_vectors_unit.sv -----
// ----------------------------------------------------------------------------
// euler_angles_to_basis_vectors_unit
// yaw-pitch-roll angles to forward, right and up basis vectors, q2.14
// ----------------------------------------------------------------------------
// channel | direction | handshake
// in      | input     | i_valid / o_stall, three angles
// out     | output    | o_valid / i_stall, nine components
// cfg     | input     | apb, register right_negated at 0
// pipeline: 30 cordic cells, then fold, two product, sum and rounding stages
// one beat per cycle; the whole pipe advances when the output is free
// synchronous active-low reset clears valid bits and the mode register
// input stall follows output stall; a held result blocks further progress
`default_nettype none
module euler_angles_to_basis_vectors_unit import eabv_pkg::*; (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_valid,
    output logic                         o_stall,
    input  wire logic signed [ANGLE_BITS-1:0] i_pitch_angle,
    input  wire logic signed [ANGLE_BITS-1:0] i_yaw_angle,
    input  wire logic signed [ANGLE_BITS-1:0] i_roll_angle,
    output logic                         o_valid,
    input  wire logic                    i_stall,
    output logic signed [OUT_W-1:0]      o_forward_x,
    output logic signed [OUT_W-1:0]      o_forward_y,
    output logic signed [OUT_W-1:0]      o_forward_z,
    output logic signed [OUT_W-1:0]      o_right_x,
    output logic signed [OUT_W-1:0]      o_right_y,
    output logic signed [OUT_W-1:0]      o_right_z,
    output logic signed [OUT_W-1:0]      o_up_x,
    output logic signed [OUT_W-1:0]      o_up_y,
    output logic signed [OUT_W-1:0]      o_up_z,
    input  wire logic                    psel,
    input  wire logic                    penable,
    input  wire logic                    pwrite,
    input  wire logic [1:0]              paddr,
    input  wire logic [31:0]             pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);
    logic r_mode;
    logic en;
    logic [LAT-1:0] r_vld;
    t_rot chain [ITERS+1][3];

    assign pready = 1'b1;
    assign prdata = {31'd0, r_mode};
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= 1'b0;
        end else if (psel && penable && pwrite && paddr == 2'(REG_RIGHT_NEGATED) << 2) begin
            r_mode <= pwdata[0];
        end
    end

    assign en = !(o_valid && i_stall);
    assign o_stall = !en;
    assign o_valid = r_vld[LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[LAT-2:0], i_valid};
        end
    end

    // seed: quadrant split of each phase
    always_comb begin
        logic [ZW-1:0] ph [3];
        ph[0] = {i_pitch_angle, {(ZW-ANGLE_BITS){1'b0}}};
        ph[1] = {i_yaw_angle, {(ZW-ANGLE_BITS){1'b0}}};
        ph[2] = {i_roll_angle, {(ZW-ANGLE_BITS){1'b0}}};
        for (int k = 0; k < 3; k++) begin
            chain[0][k].x = GAIN_INV;
            chain[0][k].y = '0;
            chain[0][k].z = ph[k] & QUARTER_MASK;
            chain[0][k].quad = ph[k][ZW-1:ZW-2];
        end
    end

    for (genvar g = 0; g < ITERS; g++) begin : g_cell
        eabv_cordic_cell u_cell (
            .i_clk(i_clk), .i_en(en), .i_step(IW'(g)), .i_rot(chain[g]),
            .o_rot(chain[g+1])
        );
    end

    // quadrant fold
    t_q30 r_c [3];
    t_q30 r_s [3];
    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                case (chain[ITERS][k].quad)
                    2'd0: begin r_c[k] <= chain[ITERS][k].x;  r_s[k] <= chain[ITERS][k].y;  end
                    2'd1: begin r_c[k] <= -chain[ITERS][k].y; r_s[k] <= chain[ITERS][k].x;  end
                    2'd2: begin r_c[k] <= -chain[ITERS][k].x; r_s[k] <= -chain[ITERS][k].y; end
                    default: begin r_c[k] <= chain[ITERS][k].y; r_s[k] <= -chain[ITERS][k].x; end
                endcase
            end
        end
    end

    // products: index 0 pitch, 1 yaw, 2 roll
    t_q30 r_cp, r_sp, r_cy, r_sy, r_cr, r_sr, r_srsp, r_crsp;
    t_q30 r_cpcy, r_cpsy, r_srcp, r_crcp;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_cp <= r_c[0]; r_sp <= r_s[0]; r_cy <= r_c[1];
            r_sy <= r_s[1]; r_cr <= r_c[2]; r_sr <= r_s[2];
            r_srsp <= mulq(r_s[2], r_s[0]);
            r_crsp <= mulq(r_c[2], r_s[0]);
            r_cpcy <= mulq(r_c[0], r_c[1]);
            r_cpsy <= mulq(r_c[0], r_s[1]);
            r_srcp <= mulq(r_s[2], r_c[0]);
            r_crcp <= mulq(r_c[2], r_c[0]);
        end
    end

    t_q30 r_p [8];
    t_q30 r_fx, r_fy, r_nsp, r_srcp2, r_up_z;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_p[0] <= mulq(r_srsp, r_cy);
            r_p[1] <= mulq(r_cr, r_sy);
            r_p[2] <= mulq(r_srsp, r_sy);
            r_p[3] <= mulq(r_cr, r_cy);
            r_p[4] <= mulq(r_crsp, r_cy);
            r_p[5] <= mulq(r_sr, r_sy);
            r_p[6] <= mulq(r_crsp, r_sy);
            r_p[7] <= mulq(r_sr, r_cy);
            r_fx <= r_cpcy; r_fy <= r_cpsy; r_nsp <= -r_sp;
            r_srcp2 <= r_srcp; r_up_z <= r_crcp;
        end
    end

    logic signed [CW+1:0] r_sum [9];
    always_ff @(posedge i_clk) begin
        logic signed [CW+1:0] a0, a1, a2;
        a0 = -(CW+2)'(r_p[0]) + (CW+2)'(r_p[1]);
        a1 = -(CW+2)'(r_p[2]) - (CW+2)'(r_p[3]);
        a2 = -(CW+2)'(r_srcp2);
        if (en) begin
            r_sum[0] <= (CW+2)'(r_fx);
            r_sum[1] <= (CW+2)'(r_fy);
            r_sum[2] <= (CW+2)'(r_nsp);
            r_sum[3] <= r_mode ? -a0 : a0;
            r_sum[4] <= r_mode ? -a1 : a1;
            r_sum[5] <= r_mode ? -a2 : a2;
            r_sum[6] <= (CW+2)'(r_p[4]) + (CW+2)'(r_p[5]);
            r_sum[7] <= (CW+2)'(r_p[6]) - (CW+2)'(r_p[7]);
            r_sum[8] <= (CW+2)'(r_up_z);
        end
    end

    logic [OUT_W-1:0] r_out [9];
    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < 9; k++) begin
                r_out[k] <= finish(r_sum[k]);
            end
        end
    end

    assign o_forward_x = r_out[0];
    assign o_forward_y = r_out[1];
    assign o_forward_z = r_out[2];
    assign o_right_x   = r_out[3];
    assign o_right_y   = r_out[4];
    assign o_right_z   = r_out[5];
    assign o_up_x      = r_out[6];
    assign o_up_y      = r_out[7];
    assign o_up_z      = r_out[8];

`ifndef ASSERT_OFF
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(r_out[0]))
        else $error("result changed under stall");
    a_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid)
        else $error("input stalled with no result held");
    a_up_z: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_up_z <= 16'sd16384 && o_up_z >= -16'sd16384)
        else $error("component out of range");
`endif
endmodule
`default_nettype wire
